@@ src/two_queue_matcher_with_cancel_top_defines.svh @@
// Assertion macros shared by the matcher's checker.
`ifndef TWO_QUEUE_MATCHER_WITH_CANCEL_TOP_DEFINES_SVH
`define TWO_QUEUE_MATCHER_WITH_CANCEL_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while rst_n is low.
`define TQM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, idle while rst_n is low.
`define TQM_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/tqm_pkg.sv @@
// Types and constants shared by the matcher's sequencer, datapath and checker.
package tqm_pkg;

    localparam int ID_W = 10;

    typedef enum logic [1:0] {
        OP_ADD_REQ = 2'd0,
        OP_ADD_SRV = 2'd1,
        OP_MATCH   = 2'd2,
        OP_CANCEL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_MATCHED  = 2'd1,
        STAT_NO_MATCH = 2'd2,
        STAT_FULL     = 2'd3
    } status_t;

    // Program steps, one-hot.
    typedef enum logic [11:0] {
        STEP_CLEAR    = 12'b0000_0000_0001,
        STEP_DISPATCH = 12'b0000_0000_0010,
        STEP_ADD_REQ  = 12'b0000_0000_0100,
        STEP_ADD_SRV  = 12'b0000_0000_1000,
        STEP_CANCEL   = 12'b0000_0001_0000,
        STEP_M_HEAD   = 12'b0000_0010_0000,
        STEP_M_ID     = 12'b0000_0100_0000,
        STEP_M_CHECK  = 12'b0000_1000_0000,
        STEP_M_SKIP   = 12'b0001_0000_0000,
        STEP_M_SRV    = 12'b0010_0000_0000,
        STEP_M_PAIR   = 12'b0100_0000_0000,
        STEP_NO_MATCH = 12'b1000_0000_0000
    } step_t;

    typedef enum logic [1:0] {
        WAIT_NONE   = 2'd0,
        WAIT_ITEM   = 2'd1,
        WAIT_RESULT = 2'd2
    } wait_t;

    typedef enum logic [2:0] {
        COND_ALWAYS    = 3'd0,
        COND_CLR_LAST  = 3'd1,
        COND_REQ_EMPTY = 3'd2,
        COND_SRV_EMPTY = 3'd3,
        COND_LIVE      = 3'd4
    } cond_t;

    // Active map write source.
    typedef enum logic [2:0] {
        AW_NONE   = 3'd0,
        AW_SWEEP  = 3'd1,
        AW_SET_ID = 3'd2,
        AW_CLR_ID = 3'd3,
        AW_CLR_R  = 3'd4
    } act_wr_t;

    // Result status source.
    typedef enum logic [2:0] {
        SS_OK       = 3'd0,
        SS_PUSH_REQ = 3'd1,
        SS_PUSH_SRV = 3'd2,
        SS_NO_MATCH = 3'd3,
        SS_MATCH    = 3'd4
    } stat_sel_t;

    typedef struct packed {
        wait_t     wait_on;
        cond_t     cond;
        step_t     on_true;
        step_t     on_false;
        logic      dispatch;
        logic      req_push;
        logic      srv_push;
        logic      req_rd;
        logic      srv_rd;
        logic      act_rd;
        logic      latch_r;
        logic      req_pop;
        logic      srv_pop;
        act_wr_t   act_wr;
        logic      emit;
        stat_sel_t stat_sel;
    } ucode_t;

    typedef struct packed {
        ucode_t uc;
        logic   go;
    } seq_cmd_t;

    typedef struct packed {
        op_t  op;
        logic item_valid;
        logic result_free;
        logic req_empty;
        logic srv_empty;
        logic live;
        logic clr_last;
    } dp_flags_t;

endpackage

@@ src/tqm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tqm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/tqm_seq.sv @@
// Microcode sequencer: step register, control store and jump logic.
module tqm_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tqm_pkg::dp_flags_t   flags,
    output tqm_pkg::seq_cmd_t    cmd
);
    import tqm_pkg::*;

    step_t  step_reg;
    step_t  step_next;
    ucode_t uc;
    logic   go;
    logic   cond_hit;

    function automatic ucode_t ucode_rom(step_t s);
        ucode_t w;
        w.wait_on  = WAIT_NONE;
        w.cond     = COND_ALWAYS;
        w.on_true  = STEP_DISPATCH;
        w.on_false = STEP_DISPATCH;
        w.dispatch = 1'b0;
        w.req_push = 1'b0;
        w.srv_push = 1'b0;
        w.req_rd   = 1'b0;
        w.srv_rd   = 1'b0;
        w.act_rd   = 1'b0;
        w.latch_r  = 1'b0;
        w.req_pop  = 1'b0;
        w.srv_pop  = 1'b0;
        w.act_wr   = AW_NONE;
        w.emit     = 1'b0;
        w.stat_sel = SS_OK;
        unique case (s)
            STEP_CLEAR:
            begin
                w.cond     = COND_CLR_LAST;
                w.on_false = STEP_CLEAR;
                w.act_wr   = AW_SWEEP;
            end
            STEP_DISPATCH:
            begin
                w.wait_on  = WAIT_ITEM;
                w.dispatch = 1'b1;
            end
            STEP_ADD_REQ:
            begin
                w.wait_on  = WAIT_RESULT;
                w.req_push = 1'b1;
                w.act_wr   = AW_SET_ID;
                w.emit     = 1'b1;
                w.stat_sel = SS_PUSH_REQ;
            end
            STEP_ADD_SRV:
            begin
                w.wait_on  = WAIT_RESULT;
                w.srv_push = 1'b1;
                w.emit     = 1'b1;
                w.stat_sel = SS_PUSH_SRV;
            end
            STEP_CANCEL:
            begin
                w.wait_on  = WAIT_RESULT;
                w.act_wr   = AW_CLR_ID;
                w.emit     = 1'b1;
            end
            STEP_M_HEAD:
            begin
                w.cond     = COND_REQ_EMPTY;
                w.on_true  = STEP_NO_MATCH;
                w.on_false = STEP_M_ID;
                w.req_rd   = 1'b1;
            end
            STEP_M_ID:
            begin
                w.on_true  = STEP_M_CHECK;
                w.act_rd   = 1'b1;
                w.latch_r  = 1'b1;
            end
            STEP_M_CHECK:
            begin
                w.cond     = COND_LIVE;
                w.on_true  = STEP_M_SRV;
                w.on_false = STEP_M_SKIP;
            end
            STEP_M_SKIP:
            begin
                w.on_true  = STEP_M_HEAD;
                w.req_pop  = 1'b1;
            end
            STEP_M_SRV:
            begin
                w.cond     = COND_SRV_EMPTY;
                w.on_true  = STEP_NO_MATCH;
                w.on_false = STEP_M_PAIR;
                w.srv_rd   = 1'b1;
            end
            STEP_M_PAIR:
            begin
                w.wait_on  = WAIT_RESULT;
                w.req_pop  = 1'b1;
                w.srv_pop  = 1'b1;
                w.act_wr   = AW_CLR_R;
                w.emit     = 1'b1;
                w.stat_sel = SS_MATCH;
            end
            STEP_NO_MATCH:
            begin
                w.wait_on  = WAIT_RESULT;
                w.emit     = 1'b1;
                w.stat_sel = SS_NO_MATCH;
            end
            default:
            begin
                w.on_true  = STEP_DISPATCH;
            end
        endcase
        return w;
    endfunction

    function automatic step_t op_entry(op_t op);
        step_t s;
        unique case (op)
            OP_ADD_REQ: s = STEP_ADD_REQ;
            OP_ADD_SRV: s = STEP_ADD_SRV;
            OP_MATCH:   s = STEP_M_HEAD;
            OP_CANCEL:  s = STEP_CANCEL;
        endcase
        return s;
    endfunction

    assign uc = ucode_rom(step_reg);

    always_comb
    begin
        unique case (uc.wait_on)
            WAIT_NONE:   go = 1'b1;
            WAIT_ITEM:   go = flags.item_valid;
            WAIT_RESULT: go = flags.result_free;
            default:     go = 1'b0;
        endcase
    end

    always_comb
    begin
        unique case (uc.cond)
            COND_ALWAYS:    cond_hit = 1'b1;
            COND_CLR_LAST:  cond_hit = flags.clr_last;
            COND_REQ_EMPTY: cond_hit = flags.req_empty;
            COND_SRV_EMPTY: cond_hit = flags.srv_empty;
            COND_LIVE:      cond_hit = flags.live;
            default:        cond_hit = 1'b1;
        endcase
    end

    always_comb
    begin
        priority if (!go)
        begin
            step_next = step_reg;
        end
        else if (uc.dispatch)
        begin
            step_next = op_entry(flags.op);
        end
        else
        begin
            step_next = cond_hit ? uc.on_true : uc.on_false;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_CLEAR;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign cmd.uc = uc;
    assign cmd.go = go;

endmodule

@@ src/tqm_dpath.sv @@
// Datapath: rings, active map, pointers, match registers and result register.
module tqm_dpath #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int ID_COUNT    = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  tqm_pkg::seq_cmd_t          cmd,
    output tqm_pkg::dp_flags_t         flags,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [1:0]                 operation,
    input  logic [tqm_pkg::ID_W-1:0]   ident,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [1:0]                 status,
    output logic [tqm_pkg::ID_W-1:0]   server_ident,
    output logic [tqm_pkg::ID_W-1:0]   requester_ident
);
    import tqm_pkg::*;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int PTR_W  = SLOT_W + 1;
    localparam int CNT_W  = PTR_W + 1;
    localparam int AMAP_W = $clog2(ID_COUNT);
    localparam logic [PTR_W-1:0]  PTR_DEPTH = PTR_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(2 * QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_SPAN  = CNT_W'(2 * QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_DEPTH = CNT_W'(QUEUE_DEPTH);
    localparam logic [AMAP_W-1:0] AMAP_LAST = AMAP_W'(ID_COUNT - 1);

    function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_slot(logic [PTR_W-1:0] p);
        return (p >= PTR_DEPTH) ? SLOT_W'(p - PTR_DEPTH) : SLOT_W'(p);
    endfunction

    function automatic logic ring_full(logic [PTR_W-1:0] h, logic [PTR_W-1:0] t);
        logic [CNT_W-1:0] cnt;
        if (t >= h)
        begin
            cnt = CNT_W'(t) - CNT_W'(h);
        end
        else
        begin
            cnt = CNT_W'(t) + CNT_SPAN - CNT_W'(h);
        end
        return cnt >= CNT_DEPTH;
    endfunction

    ucode_t             uc;
    logic               go;

    logic [ID_W-1:0]    id_reg;
    logic [ID_W-1:0]    r_reg;
    logic [PTR_W-1:0]   req_head_reg, req_head_next;
    logic [PTR_W-1:0]   req_tail_reg, req_tail_next;
    logic [PTR_W-1:0]   srv_head_reg, srv_head_next;
    logic [PTR_W-1:0]   srv_tail_reg, srv_tail_next;
    logic [AMAP_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic               result_valid_reg, result_valid_next;
    status_t            result_status_reg;
    logic [ID_W-1:0]    result_srv_reg;
    logic [ID_W-1:0]    result_req_reg;

    logic               id_ok;
    logic               r_ok;
    logic               req_full;
    logic               srv_full;
    logic               req_push_en;
    logic               srv_push_en;
    logic               emit_en;
    status_t            stat_val;

    logic               act_wr_en;
    logic [AMAP_W-1:0]  act_wr_addr;
    logic [0:0]         act_wr_data;
    logic [0:0]         act_rd_data;
    logic [ID_W-1:0]    req_rd_data;
    logic [ID_W-1:0]    srv_rd_data;

    assign uc = cmd.uc;
    assign go = cmd.go;

    assign id_ok    = 32'(id_reg) < ID_COUNT;
    assign r_ok     = 32'(r_reg) < ID_COUNT;
    assign req_full = ring_full(req_head_reg, req_tail_reg);
    assign srv_full = ring_full(srv_head_reg, srv_tail_reg);

    // Drop pushes into a full ring; ignore requester ids beyond the map.
    assign req_push_en = go && uc.req_push && id_ok && !req_full;
    assign srv_push_en = go && uc.srv_push && !srv_full;
    assign emit_en     = go && uc.emit;

    assign item_ready = (uc.wait_on == WAIT_ITEM);

    assign flags.op          = op_t'(operation);
    assign flags.item_valid  = item_valid;
    assign flags.result_free = !result_valid_reg || result_ready;
    assign flags.req_empty   = (req_head_reg == req_tail_reg);
    assign flags.srv_empty   = (srv_head_reg == srv_tail_reg);
    assign flags.live        = r_ok && act_rd_data[0];
    assign flags.clr_last    = (clr_cnt_reg == AMAP_LAST);

    // Active map write port.
    always_comb
    begin
        act_wr_en   = 1'b0;
        act_wr_addr = AMAP_W'(id_reg);
        act_wr_data = 1'b0;
        unique case (uc.act_wr)
            AW_NONE:
            begin
                act_wr_en = 1'b0;
            end
            AW_SWEEP:
            begin
                act_wr_en   = go;
                act_wr_addr = clr_cnt_reg;
            end
            AW_SET_ID:
            begin
                act_wr_en   = req_push_en;
                act_wr_data = 1'b1;
            end
            AW_CLR_ID:
            begin
                act_wr_en = go && id_ok;
            end
            AW_CLR_R:
            begin
                act_wr_en   = go && r_ok;
                act_wr_addr = AMAP_W'(r_reg);
            end
            default:
            begin
                act_wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (uc.stat_sel)
            SS_OK:       stat_val = STAT_OK;
            SS_PUSH_REQ: stat_val = (id_ok && req_full) ? STAT_FULL : STAT_OK;
            SS_PUSH_SRV: stat_val = srv_full ? STAT_FULL : STAT_OK;
            SS_NO_MATCH: stat_val = STAT_NO_MATCH;
            SS_MATCH:    stat_val = STAT_MATCHED;
            default:     stat_val = STAT_OK;
        endcase
    end

    always_comb
    begin
        req_tail_next = req_push_en ? ptr_inc(req_tail_reg) : req_tail_reg;
        srv_tail_next = srv_push_en ? ptr_inc(srv_tail_reg) : srv_tail_reg;
        req_head_next = (go && uc.req_pop) ? ptr_inc(req_head_reg) : req_head_reg;
        srv_head_next = (go && uc.srv_pop) ? ptr_inc(srv_head_reg) : srv_head_reg;
        clr_cnt_next  = (go && uc.act_wr == AW_SWEEP) ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        result_valid_next = emit_en ? 1'b1 : (result_ready ? 1'b0 : result_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_head_reg     <= '0;
            req_tail_reg     <= '0;
            srv_head_reg     <= '0;
            srv_tail_reg     <= '0;
            clr_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            req_head_reg     <= req_head_next;
            req_tail_reg     <= req_tail_next;
            srv_head_reg     <= srv_head_next;
            srv_tail_reg     <= srv_tail_next;
            clr_cnt_reg      <= clr_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            id_reg <= ident;
        end
        if (go && uc.latch_r)
        begin
            r_reg <= req_rd_data;
        end
        if (emit_en)
        begin
            result_status_reg <= stat_val;
            result_srv_reg    <= (uc.stat_sel == SS_MATCH) ? srv_rd_data : '0;
            result_req_reg    <= (uc.stat_sel == SS_MATCH) ? r_reg : '0;
        end
    end

    tqm_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_req_ring (
        .clk     (clk),
        .wr_en   (req_push_en),
        .wr_addr (ptr_slot(req_tail_reg)),
        .wr_data (id_reg),
        .rd_en   (go && uc.req_rd),
        .rd_addr (ptr_slot(req_head_reg)),
        .rd_data (req_rd_data)
    );

    tqm_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_srv_ring (
        .clk     (clk),
        .wr_en   (srv_push_en),
        .wr_addr (ptr_slot(srv_tail_reg)),
        .wr_data (id_reg),
        .rd_en   (go && uc.srv_rd),
        .rd_addr (ptr_slot(srv_head_reg)),
        .rd_data (srv_rd_data)
    );

    tqm_ram #(
        .WIDTH (1),
        .DEPTH (ID_COUNT)
    ) u_active_map (
        .clk     (clk),
        .wr_en   (act_wr_en),
        .wr_addr (act_wr_addr),
        .wr_data (act_wr_data),
        .rd_en   (go && uc.act_rd),
        .rd_addr (AMAP_W'(req_rd_data)),
        .rd_data (act_rd_data)
    );

    assign result_valid    = result_valid_reg;
    assign status          = result_status_reg;
    assign server_ident    = result_srv_reg;
    assign requester_ident = result_req_reg;

endmodule

@@ src/two_queue_matcher_with_cancel_top.sv @@
// Two-queue matcher with lazy cancel: microcoded sequencer over a ring/map datapath.
// Add requester, add server and cancel: the step for the operation loads the result
// register once it is free; only one item is in work at a time.
// Match: skips cancelled entries at the requester head, then pairs the first live one
// with the server head or reports no match on an empty ring; a held result stalls it.
// After rst_n is released the active map is cleared one id per cycle, all ID_COUNT ids.
module two_queue_matcher_with_cancel_top #(
    parameter int QUEUE_DEPTH = 1024,
    parameter int ID_COUNT    = 1024
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [1:0]                 operation,
    input  logic [tqm_pkg::ID_W-1:0]   ident,
    output logic                       result_valid,
    input  logic                       result_ready,
    output logic [1:0]                 status,
    output logic [tqm_pkg::ID_W-1:0]   server_ident,
    output logic [tqm_pkg::ID_W-1:0]   requester_ident
);
    import tqm_pkg::*;

    // Control word of the current step, qualified by its wait condition.
    seq_cmd_t  cmd;
    // Branch and wait conditions and the opcode of the item on the input channel.
    dp_flags_t flags;

    // Sequencer: holds the step register and the control store. Steps that
    // emit a result stall there until the result register is free, so an item
    // may be transferred in while the previous result still waits downstream.
    tqm_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .cmd   (cmd)
    );

    // Datapath: requester ring, server ring and active map in RAM, head and
    // tail pointers that run over twice the ring depth, the clear counter and
    // the result register that parts the output channel from the sequencer.
    tqm_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_COUNT    (ID_COUNT)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .flags           (flags),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .ident           (ident),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .server_ident    (server_ident),
        .requester_ident (requester_ident)
    );

endmodule

@@ src/tqm_checker.sv @@
// Port-level checker for the matcher, bound to the top level.
`include "two_queue_matcher_with_cancel_top_defines.svh"

module tqm_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     item_valid,
    input logic                     item_ready,
    input logic                     result_valid,
    input logic                     result_ready,
    input logic [1:0]               status,
    input logic [tqm_pkg::ID_W-1:0] server_ident,
    input logic [tqm_pkg::ID_W-1:0] requester_ident
);
    import tqm_pkg::*;

    // Hold a stalled result unchanged.
    `TQM_ASSERT_NXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(status) && $stable(server_ident) && $stable(requester_ident), "stalled result changed")

    // Zero both ids on any result other than a matched pair.
    `TQM_ASSERT_IMP(a_ids_zero, result_valid && status != STAT_MATCHED, server_ident == '0 && requester_ident == '0, "ids set without a match")

    // Drop ready right after a transfer: one item in work at a time.
    `TQM_ASSERT_NXT(a_one_item, item_valid && item_ready, !item_ready, "ready held after transfer")

    // Take no item in the first cycle out of reset: the map clear runs first.
    `TQM_ASSERT_IMP(a_clear_first, $rose(rst_n), !item_ready, "item taken before map clear")

endmodule

bind two_queue_matcher_with_cancel_top tqm_checker u_tqm_checker (.*);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the two-queue matcher with lazy requester cancel.
`timescale 1ns / 1ps

module tb_top;
    import tqm_pkg::*;

    // Geometry of the block under test, at its default parameters.
    localparam int RING_SLOTS    = 1024;
    localparam int ID_SLOTS      = 1024;
    localparam int PTR_W         = $clog2(RING_SLOTS) + 1;

    // Run shape.
    localparam int RANDOM_ITEMS  = 80;
    localparam int IDLE_PERCENT  = 37;
    localparam int SETTLE_CYCLES = 32;
    localparam int MAX_SHOWN     = 10;

    // One predicted answer of the matcher.
    typedef struct packed {
        status_t         verdict;
        logic [ID_W-1:0] server;
        logic [ID_W-1:0] requester;
    } pairing_t;

    // Every input starts at a known value before reset is released.
    logic            clk          = 1'b0;
    logic            rst_n        = 1'b0;
    logic            item_valid   = 1'b0;
    logic            item_ready;
    logic [1:0]      operation    = OP_ADD_REQ;
    logic [ID_W-1:0] ident        = '0;
    logic            result_valid;
    logic            result_ready = 1'b0;
    logic [1:0]      status;
    logic [ID_W-1:0] server_ident;
    logic [ID_W-1:0] requester_ident;

    // Shadow copy of the rings, their pointers and the active map.
    logic [ID_W-1:0]  req_ring_copy [RING_SLOTS];
    logic [ID_W-1:0]  srv_ring_copy [RING_SLOTS];
    logic [PTR_W-1:0] req_rd;
    logic [PTR_W-1:0] req_wr;
    logic [PTR_W-1:0] srv_rd;
    logic [PTR_W-1:0] srv_wr;
    bit               active_copy [ID_SLOTS];

    // Answers predicted at transfer time, oldest first.
    pairing_t awaited_pairings [$];

    // Set during stretches where neither side idles.
    bit steady = 1'b0;

    int transfers       = 0;
    int results_seen    = 0;
    int pairs_seen      = 0;
    int drops_seen      = 0;
    int skips_predicted = 0;
    int mismatches      = 0;

    two_queue_matcher_with_cancel_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .operation       (operation),
        .ident           (ident),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .status          (status),
        .server_ident    (server_ident),
        .requester_ident (requester_ident)
    );

    always #1 clk = ~clk;

    // Hard stop, far beyond the slowest legal run, including the
    // active-map clearing pass after reset and long skip loops.
    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Occupancy of a ring: pointers carry one extra wrap bit.
    function automatic int req_count();
        logic [PTR_W-1:0] diff;
        diff = req_wr - req_rd;
        return int'(diff);
    endfunction

    function automatic int srv_count();
        logic [PTR_W-1:0] diff;
        diff = srv_wr - srv_rd;
        return int'(diff);
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        return ID_W'($urandom_range((1 << ID_W) - 1));
    endfunction

    // Pick an id that sits in the requester ring right now, so a cancel hits
    // something queued; fall back to any id when the ring is empty.
    function automatic logic [ID_W-1:0] pick_queued_requester();
        int               depth;
        logic [PTR_W-1:0] p;
        depth = req_count();
        if (depth == 0)
        begin
            return rand_id();
        end
        p = req_rd + PTR_W'($urandom_range(depth - 1));
        return req_ring_copy[p[PTR_W-2:0]];
    endfunction

    // Advance the shadow state by one transfer and return the answer it owes.
    function automatic pairing_t predict_pairing(op_t op, logic [ID_W-1:0] id);
        pairing_t        res;
        logic [ID_W-1:0] head_id;
        bit              live_found;
        res = '{verdict: STAT_OK, server: '0, requester: '0};
        case (op)
            OP_ADD_REQ:
            begin
                if (id < ID_SLOTS)
                begin
                    if (req_count() >= RING_SLOTS)
                    begin
                        res.verdict = STAT_FULL;
                    end
                    else
                    begin
                        req_ring_copy[req_wr[PTR_W-2:0]] = id;
                        req_wr = req_wr + 1'b1;
                        active_copy[id] = 1'b1;
                    end
                end
            end
            OP_ADD_SRV:
            begin
                if (srv_count() >= RING_SLOTS)
                begin
                    res.verdict = STAT_FULL;
                end
                else
                begin
                    srv_ring_copy[srv_wr[PTR_W-2:0]] = id;
                    srv_wr = srv_wr + 1'b1;
                end
            end
            OP_MATCH:
            begin
                // Drop stale requesters from the head first.
                live_found = 1'b0;
                while (req_rd != req_wr && !live_found)
                begin
                    head_id = req_ring_copy[req_rd[PTR_W-2:0]];
                    if (head_id < ID_SLOTS && active_copy[head_id])
                    begin
                        live_found = 1'b1;
                    end
                    else
                    begin
                        req_rd = req_rd + 1'b1;
                        skips_predicted++;
                    end
                end
                if (req_rd == req_wr || srv_rd == srv_wr)
                begin
                    res.verdict = STAT_NO_MATCH;
                end
                else
                begin
                    res.verdict   = STAT_MATCHED;
                    res.server    = srv_ring_copy[srv_rd[PTR_W-2:0]];
                    res.requester = req_ring_copy[req_rd[PTR_W-2:0]];
                    srv_rd = srv_rd + 1'b1;
                    req_rd = req_rd + 1'b1;
                    if (res.requester < ID_SLOTS)
                    begin
                        active_copy[res.requester] = 1'b0;
                    end
                end
            end
            default:
            begin
                if (id < ID_SLOTS)
                begin
                    active_copy[id] = 1'b0;
                end
            end
        endcase
        return res;
    endfunction

    // Present one item and hold it until it transfers. Valid is left high on
    // return so back-to-back items need no gap; idle cycles drop it first.
    task automatic send_item(op_t op, logic [ID_W-1:0] id);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        operation  <= op;
        ident      <= id;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        awaited_pairings.push_back(predict_pairing(op, id));
        transfers++;
    endtask

    // Receive side: stall at random, check every result transfer against the
    // oldest prediction. Values read here are the ones from before the edge.
    always @(posedge clk)
    begin : result_check
        pairing_t due;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (status == STAT_MATCHED)
            begin
                pairs_seen++;
            end
            if (status == STAT_FULL)
            begin
                drops_seen++;
            end
            if (awaited_pairings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                begin
                    $display("[%0t] result with nothing pending: status %0d srv %h req %h",
                             $realtime, status, server_ident, requester_ident);
                end
            end
            else
            begin
                due = awaited_pairings.pop_front();
                if (status !== due.verdict || server_ident !== due.server ||
                    requester_ident !== due.requester)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                    begin
                        $display("[%0t] result %0d: wanted status %0d srv %h req %h,",
                                 $realtime, results_seen, due.verdict, due.server,
                                 due.requester);
                        $display("    got status %0d srv %h req %h",
                                 status, server_ident, requester_ident);
                    end
                end
            end
        end
        result_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Hold reset, with the shadow state cleared alongside, then release it.
    task automatic apply_reset();
        req_rd = '0;
        req_wr = '0;
        srv_rd = '0;
        srv_wr = '0;
        foreach (active_copy[i])
        begin
            active_copy[i] = 1'b0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    // Every operation, id extremes, empty rings, skip on stale head,
    // duplicate ids sharing one bit, and re-arming a cancelled id.
    task automatic test_directed_cases();
        send_item(OP_MATCH,   10'h000);  // both rings empty
        send_item(OP_ADD_SRV, 10'h3FF);
        send_item(OP_MATCH,   10'h3FF);  // servers only; ident is don't-care
        send_item(OP_ADD_REQ, 10'h000);
        send_item(OP_MATCH,   10'h000);  // pair 3FF / 000
        send_item(OP_ADD_REQ, 10'h3FF);
        send_item(OP_CANCEL,  10'h3FF);
        send_item(OP_ADD_SRV, 10'h155);
        send_item(OP_MATCH,   10'h2AA);  // skip the stale head, ring runs dry
        send_item(OP_ADD_REQ, 10'h2AA);
        send_item(OP_ADD_REQ, 10'h2AA);
        send_item(OP_ADD_REQ, 10'h155);
        send_item(OP_MATCH,   10'h000);  // pair 155 / 2AA, clears the shared bit
        send_item(OP_ADD_SRV, 10'h000);
        send_item(OP_MATCH,   10'h000);  // second 2AA copy skipped, pair 000 / 155
        send_item(OP_CANCEL,  10'h0AB);  // id never queued
        send_item(OP_ADD_REQ, 10'h007);
        send_item(OP_CANCEL,  10'h007);
        send_item(OP_ADD_REQ, 10'h007);  // re-arm: both copies live again
        send_item(OP_ADD_SRV, 10'h2AA);
        send_item(OP_ADD_SRV, 10'h0F0);
        send_item(OP_MATCH,   10'h000);  // first 007 copy matches
        send_item(OP_MATCH,   10'h000);  // second copy stale: no match
    endtask

    // Fill the requester ring to the brim with no idling on either side; the
    // tail crosses the end of the slots on the way. Cancel the head, then
    // retry it into the full ring: the drop must not set its bit again, so
    // the first match skips it and takes the one queued server. The second
    // match then finds the server ring dry.
    task automatic test_full_requester_ring();
        logic [ID_W-1:0] victim;
        steady = 1'b1;
        while (req_count() < RING_SLOTS)
        begin
            send_item(OP_ADD_REQ, rand_id());
        end
        steady = 1'b0;
        victim = req_ring_copy[req_rd[PTR_W-2:0]];
        send_item(OP_CANCEL, victim);
        send_item(OP_ADD_REQ, victim);
        repeat (24) send_item(OP_CANCEL, pick_queued_requester());
        send_item(OP_MATCH, rand_id());
        send_item(OP_MATCH, rand_id());
    endtask

    // Mixed traffic with a small pool of hot ids for duplicates, cancels
    // aimed at queued requesters, and bursts that force long skip loops.
    task automatic test_random_traffic();
        logic [ID_W-1:0] hot_ids [16];
        logic [ID_W-1:0] id;
        op_t             op;
        int              sent;
        int              pick;
        int              burst;
        foreach (hot_ids[k])
        begin
            hot_ids[k] = rand_id();
        end
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(99);
            if (pick < 6)
            begin
                burst = $urandom_range(8, 1);
                repeat (burst) send_item(OP_CANCEL, pick_queued_requester());
                send_item(OP_MATCH, rand_id());
                sent += burst + 1;
            end
            else
            begin
                if (pick < 32)
                begin
                    op = OP_ADD_REQ;
                end
                else if (pick < 56)
                begin
                    op = OP_ADD_SRV;
                end
                else if (pick < 84)
                begin
                    op = OP_MATCH;
                end
                else
                begin
                    op = OP_CANCEL;
                end
                if (op == OP_CANCEL && $urandom_range(99) < 70)
                begin
                    id = pick_queued_requester();
                end
                else if ($urandom_range(1) == 1)
                begin
                    id = hot_ids[4'($urandom_range(15))];
                end
                else
                begin
                    id = rand_id();
                end
                send_item(op, id);
                sent++;
            end
        end
    endtask

    initial
    begin
        apply_reset();
        test_directed_cases();
        test_full_requester_ring();
        test_random_traffic();

        // Drop valid, drain the pending answers, then watch for strays.
        item_valid <= 1'b0;
        while (awaited_pairings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d transfers in and %0d results out:",
                 transfers, results_seen);
        $display("%0d pairs, %0d full-ring drops, %0d stale requesters skipped, %0d mismatches.",
                 pairs_seen, drops_seen, skips_predicted, mismatches);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/tqm_pkg.sv
src/tqm_ram.sv
src/tqm_seq.sv
src/tqm_dpath.sv
src/two_queue_matcher_with_cancel_top.sv
src/tqm_checker.sv
tb/sv/tb_top.sv
